// ===== rtl/segi_pkg.sv =====
`default_nettype none
package segi_pkg;

   // default coordinate width of the segment end points
   localparam int COORD_WIDTH_DEF = 16;

   // result flags that travel with an item down the pipe
   typedef struct packed {
      logic hit;
      logic point_valid;
   } flags_type;

endpackage
`default_nettype wire

// ===== rtl/segi_req_if.sv =====
`default_nettype none
interface segi_req_if #(
   parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_start_x;
   logic signed [COORD_WIDTH-1:0] first_start_y;
   logic signed [COORD_WIDTH-1:0] first_end_x;
   logic signed [COORD_WIDTH-1:0] first_end_y;
   logic signed [COORD_WIDTH-1:0] second_start_x;
   logic signed [COORD_WIDTH-1:0] second_start_y;
   logic signed [COORD_WIDTH-1:0] second_end_x;
   logic signed [COORD_WIDTH-1:0] second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );

   modport sink (
      input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/segi_rsp_if.sv =====
`default_nettype none
interface segi_rsp_if #(
   parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic                          point_valid;
   logic signed [COORD_WIDTH-1:0] cross_x;
   logic signed [COORD_WIDTH-1:0] cross_y;

   modport source (
      output valid, hit, point_valid, cross_x, cross_y,
      input  ready
   );

   modport sink (
      input  valid, hit, point_valid, cross_x, cross_y,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/segment_intersection.sv =====
// throughput: one item per cycle when the output is not stalled; five setup stages,
//   three scaling stages, then one divider stage per quotient bit, each coordinate
//   with its own divider lane
// stalls hold every stage in place; bubbles close up while the output waits
// reset: synchronous, active high, clears all valid bits; no other state
`default_nettype none
module segment_intersection #(
   parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   segi_req_if.sink    req_ch,
   segi_rsp_if.source  rsp_ch
);
   import segi_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int TW = 2 * W + 3;
   localparam int VW = 3 * W + 4;
   localparam int ZW = W + 2;

   // front to scaler
   logic                 fr_valid, fr_ready;
   flags_type            fr_flags;
   logic signed [W:0]    fr_d1x, fr_d1y;
   logic signed [W-1:0]  fr_s1x, fr_s1y;
   logic signed [TW-1:0] fr_tn, fr_den;

   // scaler to divider
   logic                 sc_valid, sc_ready;
   flags_type            sc_flags;
   logic [VW-1:0]        sc_mag [2];
   logic                 sc_neg [2];
   logic [TW-1:0]        sc_den;
   logic signed [W-1:0]  sc_s [2];

   // divider to output
   logic                 dv_valid, dv_ready;
   flags_type            dv_flags;
   logic [W-1:0]         dv_q [2];
   logic                 dv_rem_nz [2];
   logic                 dv_neg [2];
   logic signed [W-1:0]  dv_s [2];

   logic signed [ZW-1:0] z_sum [2];
   logic signed [ZW-1:0] z_fix [2];
   logic signed [W-1:0]  cross_in [2];
   logic signed [W-1:0]  cross_ff [2];
   logic                 hit_ff, point_valid_ff;
   logic                 out_valid_ff, out_valid_in;

   segi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_ready (fr_ready),
      .out_valid (fr_valid),
      .out_flags (fr_flags),
      .out_d1x   (fr_d1x),
      .out_d1y   (fr_d1y),
      .out_s1x   (fr_s1x),
      .out_s1y   (fr_s1y),
      .out_tn    (fr_tn),
      .out_den   (fr_den)
   );

   segi_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_flags  (fr_flags),
      .in_d1x    (fr_d1x),
      .in_d1y    (fr_d1y),
      .in_s1x    (fr_s1x),
      .in_s1y    (fr_s1y),
      .in_tn     (fr_tn),
      .in_den    (fr_den),
      .out_ready (sc_ready),
      .out_valid (sc_valid),
      .out_flags (sc_flags),
      .out_mag   (sc_mag),
      .out_neg   (sc_neg),
      .out_den   (sc_den),
      .out_s     (sc_s)
   );

   segi_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sc_valid),
      .in_ready   (sc_ready),
      .in_flags   (sc_flags),
      .in_mag     (sc_mag),
      .in_neg     (sc_neg),
      .in_den     (sc_den),
      .in_s       (sc_s),
      .out_ready  (dv_ready),
      .out_valid  (dv_valid),
      .out_flags  (dv_flags),
      .out_q      (dv_q),
      .out_rem_nz (dv_rem_nz),
      .out_neg    (dv_neg),
      .out_s      (dv_s)
   );

   // output register takes a new item whenever it is empty or being drained
   assign dv_ready     = !out_valid_ff || rsp_ch.ready;
   assign out_valid_in = dv_ready ? dv_valid : out_valid_ff;

   // start point plus signed offset, then round the sum toward zero
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         z_sum[l] = dv_neg[l] ? ZW'(dv_s[l]) - $signed({2'b00, dv_q[l]})
                              : ZW'(dv_s[l]) + $signed({2'b00, dv_q[l]});
         z_fix[l] = z_sum[l];
         if (dv_rem_nz[l]) begin
            if (!dv_neg[l] && z_sum[l][ZW-1]) begin
               z_fix[l] = z_sum[l] + ZW'(1);
            end else if (dv_neg[l] && !z_sum[l][ZW-1] && (z_sum[l] != '0)) begin
               z_fix[l] = z_sum[l] - ZW'(1);
            end
         end
         cross_in[l] = dv_flags.point_valid ? z_fix[l][W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         hit_ff         <= dv_flags.hit;
         point_valid_ff <= dv_flags.point_valid;
         cross_ff       <= cross_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.hit         = hit_ff;
   assign rsp_ch.point_valid = point_valid_ff;
   assign rsp_ch.cross_x     = cross_ff[0];
   assign rsp_ch.cross_y     = cross_ff[1];

endmodule
`default_nettype wire

// ===== rtl/segi_front.sv =====
`default_nettype none
module segi_front #(
   parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   segi_req_if.sink                        req_ch,
   input  logic                            out_ready,
   output logic                            out_valid,
   output segi_pkg::flags_type             out_flags,
   output logic signed [COORD_WIDTH:0]     out_d1x,
   output logic signed [COORD_WIDTH:0]     out_d1y,
   output logic signed [COORD_WIDTH-1:0]   out_s1x,
   output logic signed [COORD_WIDTH-1:0]   out_s1y,
   output logic signed [2*COORD_WIDTH+2:0] out_tn,
   output logic signed [2*COORD_WIDTH+2:0] out_den
);
   import segi_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int PW = 2 * W + 2;
   localparam int TW = 2 * W + 3;
   localparam int NS = 5;

   function automatic logic signed [DW-1:0] sub_ext(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
      sub_ext = DW'(a) - DW'(b);
   endfunction

   // inclusive overlap of two coordinate ranges given by unordered ends
   function automatic logic ranges_meet(input logic signed [W-1:0] a0,
                                        input logic signed [W-1:0] a1,
                                        input logic signed [W-1:0] b0,
                                        input logic signed [W-1:0] b1);
      logic signed [W-1:0] alo;
      logic signed [W-1:0] ahi;
      logic signed [W-1:0] blo;
      logic signed [W-1:0] bhi;
      alo = (a0 <= a1) ? a0 : a1;
      ahi = (a0 <= a1) ? a1 : a0;
      blo = (b0 <= b1) ? b0 : b1;
      bhi = (b0 <= b1) ? b1 : b0;
      ranges_meet = (alo <= bhi) && (blo <= ahi);
   endfunction

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   adv;

   // values carried along the stages
   logic signed [DW-1:0] d1x_ff [NS];
   logic signed [DW-1:0] d1y_ff [NS];
   logic signed [W-1:0]  s1x_ff [NS];
   logic signed [W-1:0]  s1y_ff [NS];
   logic                 ovl_ff [NS-1];

   // stage 1: differences
   logic signed [DW-1:0] d1x_in, d1y_in, d2x_in, d2y_in, wx_in, wy_in;
   logic signed [DW-1:0] d2x_ff, d2y_ff, wx_ff, wy_ff;
   logic                 ovl_in;

   // stage 2: products
   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] prod_ff [6];

   // stage 3: determinant and numerators
   logic signed [TW-1:0] den2_in, tn2_in, un2_in;
   logic signed [TW-1:0] den2_ff, tn2_ff, un2_ff;

   // stage 4: sign normalized
   logic signed [TW-1:0] den3_in, tn3_in, un3_in;
   logic signed [TW-1:0] den3_ff, tn3_ff, un3_ff;
   logic                 parallel3_in, collinear3_in;
   logic                 parallel3_ff, collinear3_ff;

   // stage 5: decision
   logic                 inrange;
   flags_type            flags4_in, flags4_ff;
   logic signed [TW-1:0] den4_ff, tn4_ff;

   // stall chain
   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   assign req_ch.ready = adv[0];

   // direction vectors, offset between start points, projection overlap
   always_comb begin
      d1x_in = sub_ext(req_ch.first_end_x, req_ch.first_start_x);
      d1y_in = sub_ext(req_ch.first_end_y, req_ch.first_start_y);
      d2x_in = sub_ext(req_ch.second_end_x, req_ch.second_start_x);
      d2y_in = sub_ext(req_ch.second_end_y, req_ch.second_start_y);
      wx_in  = sub_ext(req_ch.second_start_x, req_ch.first_start_x);
      wy_in  = sub_ext(req_ch.second_start_y, req_ch.first_start_y);
      ovl_in = ranges_meet(req_ch.first_start_x, req_ch.first_end_x,
                           req_ch.second_start_x, req_ch.second_end_x) &&
               ranges_meet(req_ch.first_start_y, req_ch.first_end_y,
                           req_ch.second_start_y, req_ch.second_end_y);
   end

   // cross product terms
   always_comb begin
      prod_in[0] = PW'(d1x_ff[0]) * PW'(d2y_ff);
      prod_in[1] = PW'(d1y_ff[0]) * PW'(d2x_ff);
      prod_in[2] = PW'(wx_ff) * PW'(d2y_ff);
      prod_in[3] = PW'(wy_ff) * PW'(d2x_ff);
      prod_in[4] = PW'(wx_ff) * PW'(d1y_ff[0]);
      prod_in[5] = PW'(wy_ff) * PW'(d1x_ff[0]);
   end

   // determinant and the two line parameters' numerators
   always_comb begin
      den2_in = TW'(prod_ff[0]) - TW'(prod_ff[1]);
      tn2_in  = TW'(prod_ff[2]) - TW'(prod_ff[3]);
      un2_in  = TW'(prod_ff[4]) - TW'(prod_ff[5]);
   end

   // make the determinant non-negative
   always_comb begin
      den3_in       = den2_ff[TW-1] ? -den2_ff : den2_ff;
      tn3_in        = den2_ff[TW-1] ? -tn2_ff : tn2_ff;
      un3_in        = den2_ff[TW-1] ? -un2_ff : un2_ff;
      parallel3_in  = (den2_ff == '0);
      collinear3_in = (tn2_ff == '0) && (un2_ff == '0);
   end

   // both parameters in [0,1], or collinear overlap when parallel
   always_comb begin
      inrange = !tn3_ff[TW-1] && (tn3_ff <= den3_ff) &&
                !un3_ff[TW-1] && (un3_ff <= den3_ff);
      flags4_in.hit         = parallel3_ff ? (collinear3_ff && ovl_ff[NS-2]) : inrange;
      flags4_in.point_valid = !parallel3_ff && inrange;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d1x_ff[0] <= d1x_in;
         d1y_ff[0] <= d1y_in;
         s1x_ff[0] <= req_ch.first_start_x;
         s1y_ff[0] <= req_ch.first_start_y;
         ovl_ff[0] <= ovl_in;
         d2x_ff    <= d2x_in;
         d2y_ff    <= d2y_in;
         wx_ff     <= wx_in;
         wy_ff     <= wy_in;
      end
      for (int k = 1; k < NS; k++) begin
         if (adv[k]) begin
            d1x_ff[k] <= d1x_ff[k - 1];
            d1y_ff[k] <= d1y_ff[k - 1];
            s1x_ff[k] <= s1x_ff[k - 1];
            s1y_ff[k] <= s1y_ff[k - 1];
         end
      end
      for (int k = 1; k < NS - 1; k++) begin
         if (adv[k]) begin
            ovl_ff[k] <= ovl_ff[k - 1];
         end
      end
      if (adv[1]) begin
         prod_ff <= prod_in;
      end
      if (adv[2]) begin
         den2_ff <= den2_in;
         tn2_ff  <= tn2_in;
         un2_ff  <= un2_in;
      end
      if (adv[3]) begin
         den3_ff       <= den3_in;
         tn3_ff        <= tn3_in;
         un3_ff        <= un3_in;
         parallel3_ff  <= parallel3_in;
         collinear3_ff <= collinear3_in;
      end
      if (adv[4]) begin
         flags4_ff <= flags4_in;
         den4_ff   <= den3_ff;
         tn4_ff    <= tn3_ff;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_flags = flags4_ff;
   assign out_d1x   = d1x_ff[NS-1];
   assign out_d1y   = d1y_ff[NS-1];
   assign out_s1x   = s1x_ff[NS-1];
   assign out_s1y   = s1y_ff[NS-1];
   assign out_tn    = tn4_ff;
   assign out_den   = den4_ff;

endmodule
`default_nettype wire

// ===== rtl/segi_scale.sv =====
`default_nettype none
module segi_scale #(
   parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  segi_pkg::flags_type             in_flags,
   input  logic signed [COORD_WIDTH:0]     in_d1x,
   input  logic signed [COORD_WIDTH:0]     in_d1y,
   input  logic signed [COORD_WIDTH-1:0]   in_s1x,
   input  logic signed [COORD_WIDTH-1:0]   in_s1y,
   input  logic signed [2*COORD_WIDTH+2:0] in_tn,
   input  logic signed [2*COORD_WIDTH+2:0] in_den,
   input  logic                            out_ready,
   output logic                            out_valid,
   output segi_pkg::flags_type             out_flags,
   output logic [3*COORD_WIDTH+3:0]        out_mag [2],
   output logic                            out_neg [2],
   output logic [2*COORD_WIDTH+2:0]        out_den,
   output logic signed [COORD_WIDTH-1:0]   out_s [2]
);
   import segi_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;
   localparam int TW  = 2 * W + 3;
   localparam int LW  = W + 2;
   localparam int HW  = TW - LW;
   localparam int PLW = DW + LW + 1;
   localparam int PHW = DW + HW + 1;
   localparam int VW  = 3 * W + 4;
   localparam int NS  = 3;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   adv;

   logic signed [DW-1:0]  d_lane [2];
   logic signed [W-1:0]   s_lane [2];

   flags_type             flags_ff [NS];
   logic [TW-1:0]         den_ff [NS];
   logic signed [W-1:0]   s_ff [NS][2];

   logic signed [PLW-1:0] plo_in [2];
   logic signed [PLW-1:0] plo_ff [2];
   logic signed [PHW-1:0] phi_in [2];
   logic signed [PHW-1:0] phi_ff [2];
   logic signed [VW-1:0]  v_in [2];
   logic signed [VW-1:0]  v_ff [2];
   logic [VW-1:0]         mag_in [2];
   logic [VW-1:0]         mag_ff [2];
   logic                  neg_in [2];
   logic                  neg_ff [2];

   // stall chain
   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   assign in_ready = adv[0];

   assign d_lane[0] = in_d1x;
   assign d_lane[1] = in_d1y;
   assign s_lane[0] = in_s1x;
   assign s_lane[1] = in_s1y;

   // d * tn as two partial products over the low and high halves of tn
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         plo_in[l] = PLW'(d_lane[l]) * PLW'($signed({1'b0, in_tn[LW-1:0]}));
         phi_in[l] = PHW'(d_lane[l]) * PHW'($signed({1'b0, in_tn[TW-1:LW]}));
      end
   end

   // combine the partial products
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         v_in[l] = (VW'(phi_ff[l]) <<< LW) + VW'(plo_ff[l]);
      end
   end

   // sign and magnitude for the divider
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         neg_in[l] = v_ff[l][VW-1];
         mag_in[l] = $unsigned(v_ff[l][VW-1] ? -v_ff[l] : v_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         flags_ff[0] <= in_flags;
         den_ff[0]   <= in_den;
         s_ff[0]     <= s_lane;
         plo_ff      <= plo_in;
         phi_ff      <= phi_in;
      end
      for (int k = 1; k < NS; k++) begin
         if (adv[k]) begin
            flags_ff[k] <= flags_ff[k - 1];
            den_ff[k]   <= den_ff[k - 1];
            s_ff[k]     <= s_ff[k - 1];
         end
      end
      if (adv[1]) begin
         v_ff <= v_in;
      end
      if (adv[2]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_flags = flags_ff[NS-1];
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;
   assign out_den   = den_ff[NS-1];
   assign out_s     = s_ff[NS-1];

endmodule
`default_nettype wire

// ===== rtl/segi_div.sv =====
`default_nettype none
module segi_div #(
   parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  segi_pkg::flags_type           in_flags,
   input  logic [3*COORD_WIDTH+3:0]      in_mag [2],
   input  logic                          in_neg [2],
   input  logic [2*COORD_WIDTH+2:0]      in_den,
   input  logic signed [COORD_WIDTH-1:0] in_s [2],
   input  logic                          out_ready,
   output logic                          out_valid,
   output segi_pkg::flags_type           out_flags,
   output logic [COORD_WIDTH-1:0]        out_q [2],
   output logic                          out_rem_nz [2],
   output logic                          out_neg [2],
   output logic signed [COORD_WIDTH-1:0] out_s [2]
);
   import segi_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int TW = 2 * W + 3;
   localparam int VW = 3 * W + 4;
   // one quotient bit per stage
   localparam int NS = W;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   adv;

   logic [VW-1:0]       rem_ff [NS][2];
   logic [VW-1:0]       rem_in [NS][2];
   logic [W-1:0]        q_ff [NS][2];
   logic [W-1:0]        q_in [NS][2];
   logic [TW-1:0]       den_ff [NS-1];
   logic                neg_ff [NS][2];
   logic signed [W-1:0] s_ff [NS][2];
   flags_type           flags_ff [NS];

   logic [VW-1:0]       src_rem [NS][2];
   logic [W-1:0]        src_q [NS][2];
   logic [TW-1:0]       src_den [NS];
   logic                ge [NS][2];

   // stall chain
   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   assign in_ready = adv[0];

   // operands seen by each stage
   always_comb begin
      src_den[0] = in_den;
      for (int l = 0; l < 2; l++) begin
         src_rem[0][l] = in_mag[l];
         src_q[0][l]   = '0;
      end
      for (int k = 1; k < NS; k++) begin
         src_den[k] = den_ff[k - 1];
         for (int l = 0; l < 2; l++) begin
            src_rem[k][l] = rem_ff[k - 1][l];
            src_q[k][l]   = q_ff[k - 1][l];
         end
      end
   end

   // restoring step against the shifted divisor
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         for (int l = 0; l < 2; l++) begin
            ge[k][l]     = src_rem[k][l] >= (VW'(src_den[k]) << (W - 1 - k));
            rem_in[k][l] = ge[k][l] ? src_rem[k][l] - (VW'(src_den[k]) << (W - 1 - k))
                                    : src_rem[k][l];
            q_in[k][l]   = src_q[k][l] | (W'(ge[k][l]) << (W - 1 - k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         flags_ff[0] <= in_flags;
         neg_ff[0]   <= in_neg;
         s_ff[0]     <= in_s;
      end
      for (int k = 1; k < NS; k++) begin
         if (adv[k]) begin
            flags_ff[k] <= flags_ff[k - 1];
            neg_ff[k]   <= neg_ff[k - 1];
            s_ff[k]     <= s_ff[k - 1];
         end
      end
      for (int k = 0; k < NS - 1; k++) begin
         if (adv[k]) begin
            den_ff[k] <= src_den[k];
         end
      end
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_flags = flags_ff[NS-1];
   assign out_q     = q_ff[NS-1];
   assign out_neg   = neg_ff[NS-1];
   assign out_s     = s_ff[NS-1];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         out_rem_nz[l] = |rem_ff[NS-1][l];
      end
   end

endmodule
`default_nettype wire
